// ===== sv/cfed_pkg.sv =====
package cfed_pkg;

    localparam int TAPS_DEFAULT = 64;
    localparam int COEFF_LEN    = 64;
    localparam int COEFF_W      = 7;
    localparam int SAMPLE_W     = 16;
    localparam int ENERGY_W     = 32;
    localparam int CFG_ADDR_W   = 1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_HIGH = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_LOW  = 1'b1;

    // Per-cycle controls from the sequencer to the datapath.
    typedef struct packed {
        logic clear;
        logic mac_en;
        logic sq_re_en;
        logic sq_im_en;
    } dp_ctrl_t;

    localparam logic signed [COEFF_W-1:0] WEIGHT_REAL [COEFF_LEN] = '{
        7'sd13,  7'sd14,  7'sd11,  7'sd5,  -7'sd4,  -7'sd14, -7'sd23, -7'sd28,
        -7'sd28, -7'sd22, -7'sd10, 7'sd4,  7'sd19,  7'sd30,  7'sd36,  7'sd34,
        7'sd26,  7'sd13,  -7'sd2,  -7'sd16, -7'sd25, -7'sd28, -7'sd26, -7'sd19,
        -7'sd10, 7'sd0,   7'sd8,   7'sd13, 7'sd14,  7'sd12,  7'sd9,   7'sd4,
        7'sd0,   -7'sd2,  -7'sd4,  -7'sd4, -7'sd4,  -7'sd2,  -7'sd1,  7'sd0,
        7'sd0,   7'sd1,   7'sd1,   7'sd1,  7'sd0,   7'sd0,   7'sd0,   7'sd0,
        7'sd0,   7'sd0,   7'sd0,   7'sd0,  7'sd0,   7'sd0,   7'sd0,   7'sd0,
        7'sd0,   7'sd0,   7'sd0,   7'sd0,  7'sd0,   7'sd0,   7'sd0,   7'sd0
    };

    localparam logic signed [COEFF_W-1:0] WEIGHT_IMAG [COEFF_LEN] = '{
        7'sd0,   7'sd6,   7'sd13,  7'sd19, 7'sd21,  7'sd19,  7'sd12,  7'sd2,
        -7'sd11, -7'sd23, -7'sd31, -7'sd34, -7'sd30, -7'sd19, -7'sd5, 7'sd11,
        7'sd24,  7'sd32,  7'sd34,  7'sd28, 7'sd18,  7'sd5,   -7'sd7,  -7'sd16,
        -7'sd21, -7'sd21, -7'sd17, -7'sd10, -7'sd4, 7'sd2,   7'sd6,   7'sd8,
        7'sd8,   7'sd6,   7'sd4,   7'sd1,  7'sd0,   -7'sd2,  -7'sd2,  -7'sd2,
        -7'sd1,  -7'sd1,  7'sd0,   7'sd0,  7'sd0,   7'sd0,   7'sd0,   7'sd0,
        7'sd0,   7'sd0,   7'sd0,   7'sd0,  7'sd0,   7'sd0,   7'sd0,   7'sd0,
        7'sd0,   7'sd0,   7'sd0,   7'sd0,  7'sd0,   7'sd0,   7'sd0,   7'sd0
    };

    // Taps past the end of the table have a zero coefficient.
    function automatic logic signed [COEFF_W-1:0] weight_real(input logic [7:0] k);
        logic signed [COEFF_W-1:0] c;
        c = '0;
        if (k < 8'(COEFF_LEN)) begin
            c = WEIGHT_REAL[k[5:0]];
        end
        return c;
    endfunction

    function automatic logic signed [COEFF_W-1:0] weight_imag(input logic [7:0] k);
        logic signed [COEFF_W-1:0] c;
        c = '0;
        if (k < 8'(COEFF_LEN)) begin
            c = WEIGHT_IMAG[k[5:0]];
        end
        return c;
    endfunction

endpackage

// ===== sv/complex_fir_energy_detector.sv =====
// Complex FIR energy detector with hysteresis.
// Input channel s_*: one signed 16-bit sample per transaction. Output channel
// m_*: one result per sample with the saturated energy |re|^2 + |im|^2 of the
// complex filter output, a saturation flag and the hysteresis detection flag.
// cfg_*: plain write port; index 0 is the on-threshold, index 1 the
// off-threshold. A write to another index is ignored. Write only while idle.
// Samples live in a ring memory of TAPS entries; one complex multiply-accumulate
// walks the taps, newest first, one memory read per cycle.
// An item goes from acceptance to a valid result through the tap walk over the
// single memory read port, a drain state for the read pipeline, squaring
// states for the real and imaginary parts and the output stage. The next
// sample is accepted once the previous result has been loaded into the output
// register, so the block takes no new sample while one is still in flight.
// Reset clears thresholds to their defaults and the detection flag. The ring
// reads as zero until written, tracked by a fill count, so no clearing pass
// is needed. If the receiver stalls, the result holds in the output register;
// a following sample is still taken and processed, and its result waits in
// the final stage until the register frees up.
module complex_fir_energy_detector #(
    parameter int TAPS = cfed_pkg::TAPS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // [15:0] sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] energy, [32] energy_saturated, [33] detect_active, [39:34] zero
    output logic [39:0]                         m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [cfed_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [cfed_pkg::ENERGY_W-1:0]       cfg_wdata
);

    localparam int TAP_W  = $clog2(TAPS);
    localparam int FILL_W = $clog2(TAPS + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_RUN    = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_SQ_RE  = 6'b001000,
        S_SQ_IM  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [TAP_W-1:0]                slot_reg, slot_next;
    logic [FILL_W-1:0]               fill_reg;
    logic [TAP_W-1:0]                tap_reg;
    logic [TAP_W-1:0]                rd_tap_reg;
    logic                            rd_valid_reg;
    logic                            detect_reg, detect_next;
    logic [cfed_pkg::ENERGY_W-1:0]   thr_high_reg;
    logic [cfed_pkg::ENERGY_W-1:0]   thr_low_reg;
    logic                            out_valid_reg;
    logic [cfed_pkg::ENERGY_W-1:0]   out_energy_reg;
    logic                            out_sat_reg;
    logic                            out_detect_reg;

    logic                            accept;
    logic                            out_load;
    logic                            last_tap;
    logic [TAP_W:0]                  addr_wide;
    logic [TAP_W-1:0]                rd_addr;
    logic [cfed_pkg::SAMPLE_W-1:0]   ram_rdata;
    logic signed [cfed_pkg::SAMPLE_W-1:0] mac_sample;
    cfed_pkg::dp_ctrl_t              dp_ctrl;
    logic [cfed_pkg::ENERGY_W-1:0]   energy;
    logic                            energy_sat;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || m_tready);
    assign last_tap = (tap_reg == TAP_W'(TAPS - 1));

    assign slot_next = (slot_reg == TAP_W'(TAPS - 1)) ? '0 : slot_reg + 1'b1;

    // Tap k reads the slot k places behind the newest one, modulo TAPS.
    always_comb begin
        if (slot_reg >= tap_reg) begin
            addr_wide = {1'b0, slot_reg} - {1'b0, tap_reg};
        end else begin
            addr_wide = (TAP_W + 1)'(TAPS) + {1'b0, slot_reg} - {1'b0, tap_reg};
        end
    end
    assign rd_addr = addr_wide[TAP_W-1:0];

    cfed_ram #(
        .WIDTH(cfed_pkg::SAMPLE_W),
        .DEPTH(TAPS)
    ) u_ring (
        .clk  (aclk),
        .we   (accept),
        .waddr(slot_next),
        .wdata(s_tdata),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    // Slots not yet written since reset read as zero.
    assign mac_sample = (FILL_W'(rd_tap_reg) < fill_reg) ? $signed(ram_rdata) : '0;

    assign dp_ctrl.clear    = accept;
    assign dp_ctrl.mac_en   = rd_valid_reg;
    assign dp_ctrl.sq_re_en = (state_reg == S_SQ_RE);
    assign dp_ctrl.sq_im_en = (state_reg == S_SQ_IM);

    cfed_datapath #(
        .TAPS(TAPS)
    ) u_datapath (
        .aclk       (aclk),
        .ctrl_i     (dp_ctrl),
        .sample_i   (mac_sample),
        .tap_i      (rd_tap_reg),
        .energy_o   (energy),
        .saturated_o(energy_sat)
    );

    always_comb begin
        detect_next = detect_reg;
        if (energy > thr_high_reg && !detect_reg) begin
            detect_next = 1'b1;
        end else if (energy < thr_low_reg && detect_reg) begin
            detect_next = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_RUN;
            end
            S_RUN: begin
                if (last_tap) state_next = S_DRAIN;
            end
            S_DRAIN:  state_next = S_SQ_RE;
            S_SQ_RE:  state_next = S_SQ_IM;
            S_SQ_IM:  state_next = S_FINISH;
            S_FINISH: begin
                if (out_load) state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            tap_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            detect_reg    <= 1'b0;
            thr_high_reg  <= '1;
            thr_low_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == S_RUN);
            if (accept) begin
                slot_reg <= slot_next;
                tap_reg  <= '0;
                if (fill_reg != FILL_W'(TAPS)) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end else if (state_reg == S_RUN) begin
                tap_reg <= tap_reg + 1'b1;
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    cfed_pkg::REG_THRESHOLD_HIGH: thr_high_reg <= cfg_wdata;
                    cfed_pkg::REG_THRESHOLD_LOW:  thr_low_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
                detect_reg    <= detect_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_tap_reg <= tap_reg;
        if (out_load) begin
            out_energy_reg <= energy;
            out_sat_reg    <= energy_sat;
            out_detect_reg <= detect_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_detect_reg, out_sat_reg, out_energy_reg};

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result became valid outside the output stage");

    a_accept_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_RUN) && (tap_reg == '0))
        else $error("tap walk did not start at the newest sample");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(TAPS))
        else $error("fill count ran past the ring depth");

    a_read_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (state_reg == S_RUN) || (state_reg == S_DRAIN))
        else $error("ring read data arrived outside the tap walk");

    a_sat_clamps: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_sat_reg) |-> (out_energy_reg == '1))
        else $error("saturated energy was not clamped");

endmodule

// ===== sv/cfed_ram.sv =====
module cfed_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/cfed_datapath.sv =====
module cfed_datapath #(
    parameter int TAPS = cfed_pkg::TAPS_DEFAULT
) (
    input  logic                                  aclk,
    input  cfed_pkg::dp_ctrl_t                    ctrl_i,
    input  logic signed [cfed_pkg::SAMPLE_W-1:0]  sample_i,
    input  logic [$clog2(TAPS)-1:0]               tap_i,
    output logic [cfed_pkg::ENERGY_W-1:0]         energy_o,
    output logic                                  saturated_o
);

    localparam int TAP_W  = $clog2(TAPS);
    localparam int PROD_W = cfed_pkg::SAMPLE_W + cfed_pkg::COEFF_W;
    localparam int ACC_W  = PROD_W + TAP_W;
    localparam int SQ_W   = 2 * ACC_W;

    logic signed [cfed_pkg::COEFF_W-1:0] c_re;
    logic signed [cfed_pkg::COEFF_W-1:0] c_im;
    logic signed [PROD_W-1:0]            prod_re;
    logic signed [PROD_W-1:0]            prod_im;
    logic signed [ACC_W-1:0]             acc_re_reg;
    logic signed [ACC_W-1:0]             acc_im_reg;
    logic signed [SQ_W-1:0]              sq_re;
    logic signed [SQ_W-1:0]              sq_im;
    logic [SQ_W-1:0]                     sq_re_reg;
    logic [SQ_W:0]                       total_reg;

    assign c_re    = cfed_pkg::weight_real(8'(tap_i));
    assign c_im    = cfed_pkg::weight_imag(8'(tap_i));
    assign prod_re = sample_i * c_re;
    assign prod_im = sample_i * c_im;

    // A square is never negative, so its bits read as an unsigned value.
    assign sq_re = acc_re_reg * acc_re_reg;
    assign sq_im = acc_im_reg * acc_im_reg;

    always_ff @(posedge aclk) begin
        if (ctrl_i.clear) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (ctrl_i.mac_en) begin
            acc_re_reg <= acc_re_reg + ACC_W'(prod_re);
            acc_im_reg <= acc_im_reg + ACC_W'(prod_im);
        end
        if (ctrl_i.sq_re_en) begin
            sq_re_reg <= $unsigned(sq_re);
        end
        if (ctrl_i.sq_im_en) begin
            total_reg <= {1'b0, sq_re_reg} + {1'b0, $unsigned(sq_im)};
        end
    end

    assign saturated_o = |total_reg[SQ_W:cfed_pkg::ENERGY_W];
    assign energy_o    = saturated_o ? '1 : total_reg[cfed_pkg::ENERGY_W-1:0];

endmodule

// ===== tb/sv/complex_fir_energy_detector_test.sv =====
`timescale 1ns / 1ps

module complex_fir_energy_detector_test;

    localparam int RING_DEPTH   = cfed_pkg::TAPS_DEFAULT;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 650;
    localparam int PHASE_COUNT  = 6;

    typedef struct {
        logic [cfed_pkg::ENERGY_W-1:0] energy;
        bit                            saturated;
        bit                            detect;
    } energy_result_t;

    // Tracks the filter state and the hysteresis flag, and holds the energy results
    // still owed by the block, oldest first.
    class energy_scoreboard;
        logic signed [cfed_pkg::SAMPLE_W-1:0] history [RING_DEPTH];
        int unsigned                          newest;
        bit                                   detect_on;
        logic [cfed_pkg::ENERGY_W-1:0]        on_level;
        logic [cfed_pkg::ENERGY_W-1:0]        off_level;
        energy_result_t                       owed_q [$];
        int unsigned                          errors;

        function new();
            foreach (history[i]) history[i] = '0;
            newest    = 0;
            detect_on = 1'b0;
            on_level  = '1;
            off_level = '0;
            errors    = 0;
        endfunction

        function void set_threshold(logic [cfed_pkg::CFG_ADDR_W-1:0] idx,
                                    logic [cfed_pkg::ENERGY_W-1:0] value);
            if (idx == cfed_pkg::REG_THRESHOLD_HIGH) begin
                on_level = value;
            end else if (idx == cfed_pkg::REG_THRESHOLD_LOW) begin
                off_level = value;
            end
        endfunction

        function void note_sample(logic [cfed_pkg::SAMPLE_W-1:0] raw);
            longint            re_sum;
            longint            im_sum;
            longint            c_re;
            longint            c_im;
            longint unsigned   total;
            int unsigned       pos;
            energy_result_t    res;
            re_sum = 0;
            im_sum = 0;
            newest = (newest + 1) % RING_DEPTH;
            history[newest] = raw;
            pos = newest;
            for (int k = 0; k < RING_DEPTH; k++) begin
                c_re = (k < cfed_pkg::COEFF_LEN) ? longint'(cfed_pkg::WEIGHT_REAL[k]) : 0;
                c_im = (k < cfed_pkg::COEFF_LEN) ? longint'(cfed_pkg::WEIGHT_IMAG[k]) : 0;
                re_sum += longint'(history[pos]) * c_re;
                im_sum += longint'(history[pos]) * c_im;
                pos = (pos == 0) ? RING_DEPTH - 1 : pos - 1;
            end
            total = longint'(re_sum * re_sum) + longint'(im_sum * im_sum);
            res.saturated = (total > 64'hFFFF_FFFF);
            res.energy    = res.saturated ? '1 : total[cfed_pkg::ENERGY_W-1:0];
            // Strict compares: an energy equal to a threshold leaves the flag alone.
            if (res.energy > on_level && !detect_on) begin
                detect_on = 1'b1;
            end else if (res.energy < off_level && detect_on) begin
                detect_on = 1'b0;
            end
            res.detect = detect_on;
            owed_q.push_back(res);
        endfunction

        function void check_result(logic [39:0] data);
            energy_result_t want;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h", $time, data);
                return;
            end
            want = owed_q.pop_front();
            if (data[31:0] !== want.energy) begin
                errors++;
                $display("%0t: energy mismatch, expected %h actual %h",
                         $time, want.energy, data[31:0]);
            end
            if (data[32] !== want.saturated) begin
                errors++;
                $display("%0t: saturation flag mismatch, expected %b actual %b",
                         $time, want.saturated, data[32]);
            end
            if (data[33] !== want.detect) begin
                errors++;
                $display("%0t: detect flag mismatch, expected %b actual %b",
                         $time, want.detect, data[33]);
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [15:0]                     s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [39:0]                     m_tdata;
    logic                            cfg_wr_en;
    logic [cfed_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [cfed_pkg::ENERGY_W-1:0]   cfg_wdata;

    energy_scoreboard sb = new();
    int unsigned      sender_idle_pct;
    int unsigned      receiver_idle_pct;
    int unsigned      results_seen;
    int unsigned      cycle_count;
    bit               held_off;

    complex_fir_energy_detector uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Before each offer the sender stays idle for a random number of cycles.
    task automatic send_sample(logic [15:0] value);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(value);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic load_thresholds(logic [cfed_pkg::ENERGY_W-1:0] high,
                                   logic [cfed_pkg::ENERGY_W-1:0] low);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= cfed_pkg::REG_THRESHOLD_HIGH;
        cfg_wdata <= high;
        sb.set_threshold(cfed_pkg::REG_THRESHOLD_HIGH, high);
        @(negedge aclk);
        cfg_addr  <= cfed_pkg::REG_THRESHOLD_LOW;
        cfg_wdata <= low;
        sb.set_threshold(cfed_pkg::REG_THRESHOLD_LOW, low);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly small amplitudes, since almost any full-scale sample saturates the energy.
    function automatic logic [15:0] random_sample();
        int unsigned pick;
        int          value;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            value = 0;
        end else if (pick < 55) begin
            value = int'($urandom_range(0, 128)) - 64;
        end else if (pick < 80) begin
            value = int'($urandom_range(0, 4096)) - 2048;
        end else begin
            value = int'($urandom_range(0, 65535));
        end
        return value[15:0];
    endfunction

    initial begin
        results_seen = 0;
        held_off     = 1'b0;
        forever begin
            @(negedge aclk);
            // One long stall lets the output and final stages fill and back up the input.
            if (!held_off && results_seen == 150) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (700) @(negedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
                results_seen++;
            end
        end
    end

    initial begin
        logic [15:0]                   extreme_samples [8];
        logic [cfed_pkg::ENERGY_W-1:0] high;
        logic [cfed_pkg::ENERGY_W-1:0] low;
        int unsigned                   random_sent;

        extreme_samples = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
                            16'h8000, 16'h5555, 16'hAAAA, 16'h0000};
        random_sent       = 0;
        cycle_count       = 0;
        sender_idle_pct   = 19;
        receiver_idle_pct = 86;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = cfed_pkg::REG_THRESHOLD_HIGH;
        cfg_wdata = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // From an empty ring: a saturated energy turns detection on, then a sample
        // that nearly cancels the real sum drops the energy below the off level.
        load_thresholds(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_sample(16'd10000);
        send_sample(-16'sd10769);
        send_sample(16'h0000);
        wait_idle();

        // Saturated energies here equal the on level and cannot turn detection on; the last sample above left it on.
        load_thresholds(32'hFFFF_FFFF, 32'h0000_0000);
        foreach (extreme_samples[i]) send_sample(extreme_samples[i]);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_idle();
            case (phase) inside
                0: begin
                    high = '0;
                    low  = '0;
                end
                1, 4: begin
                    high = $urandom_range(32'd1_000_000, 32'd1_000_000_000);
                    low  = high >> $urandom_range(1, 4);
                end
                2: begin
                    high = 32'hFFFF_FFFE;
                    low  = 32'hFFFF_FFFF;
                end
                3: begin
                    high = $urandom;
                    low  = $urandom;
                end
                default: begin
                    high = 32'hFFFF_FFFF;
                    low  = 32'h0000_0000;
                end
            endcase
            load_thresholds(high, low);
            for (int n = 0; n < RANDOM_ITEMS / PHASE_COUNT + 1; n++) begin
                if (random_sent < RANDOM_ITEMS / 3) begin
                    sender_idle_pct   = 19;
                    receiver_idle_pct = 86;
                end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
                    sender_idle_pct   = 86;
                    receiver_idle_pct = 19;
                end else begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
                send_sample(random_sample());
                random_sent++;
            end
        end

        wait_idle();
        repeat (cfed_pkg::TAPS_DEFAULT + 25) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== complex_fir_energy_detector.f =====
sv/cfed_pkg.sv
sv/cfed_ram.sv
sv/cfed_datapath.sv
sv/complex_fir_energy_detector.sv
tb/sv/complex_fir_energy_detector_test.sv
